// ----- rtl/mac_pkg.sv -----
// Shared types, constants and fixed-point helpers for the modulated allpass cascade.
package mac_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_M1   = 10'b00_0000_0010,
    S_M2   = 10'b00_0000_0100,
    S_M3   = 10'b00_0000_1000,
    S_M4   = 10'b00_0001_0000,
    S_P1   = 10'b00_0010_0000,
    S_Y    = 10'b00_0100_0000,
    S_P2   = 10'b00_1000_0000,
    S_WR   = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

  // 0.965 * 2^24, truncated.
  localparam logic signed [31:0] C965     = 32'sd16190013;
  // 2.0 in Q1.16 depth format.
  localparam logic [17:0]        DEPTH_ONE = 18'd131072;

  // Q.30 x Q.23 product back to Q.23, round half up.
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return t >>> 30;
  endfunction

  // Saturate to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate to the 24-bit signed range.
  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > 32'sd8388607) begin
      r = 24'sh7F_FFFF;
    end else if (v < -32'sd8388608) begin
      r = 24'sh80_0000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Coefficient from its 2^-41 sum: round to Q.30, clamp to [-2^30, 2^30 - 1].
  function automatic logic signed [30:0] coef_q30(input logic signed [47:0] acc);
    logic signed [47:0] t;
    logic signed [30:0] r;
    t = (acc + 48'sd1024) >>> 11;
    if (t > 48'sd1073741823) begin
      r = 31'sh3FFF_FFFF;
    end else if (t < -48'sd1073741824) begin
      r = 31'sh4000_0000;
    end else begin
      r = t[30:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/mac_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/modulated_allpass_cascade.sv -----
// Top level: modulated first-order allpass cascade over one shared multiplier.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in_     | input     | in_valid / in_ready  | sample_in, chan, mod_in, depth_in,
//          |           |                      | block_last
//  out_    | output    | out_valid/out_ready  | sample_out, block_last_out
//
// Sequence: a request runs S_M1 to S_M4, then S_P1, S_Y, S_P2 and S_WR for each section,
//   then S_DONE until the output is free; the single 32x32 multiplier sets the pace: two products
//   build the coefficient, then each section needs m*x and m*y.
// Reset: sequencer and output valid clear; per-entry valid bits make the section
//   state read as zero until written, so there is no clearing pass.
// Stalls: in_ready is high only while idle; a done result waits for a free output.
module modulated_allpass_cascade #(
  parameter int NUM_STAGES   = 4,
  parameter int NUM_CHANNELS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_sample_in,
  input  logic               in_chan,
  input  logic signed [15:0] in_mod_in,
  input  logic [16:0]        in_depth_in,
  input  logic               in_block_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_sample_out,
  output logic               out_block_last_out
);
  import mac_pkg::*;

  localparam int DEPTH  = NUM_CHANNELS * NUM_STAGES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STG_W  = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

  state_t state_r, state_nxt;

  // Latched request
  logic signed [31:0] x_r;          // running section input, Q9.23
  logic               ch_r;         // channel, already reduced to the count
  logic signed [15:0] mod_r;
  logic [16:0]        depth_r;
  logic               last_r;

  // Datapath
  logic signed [63:0] prod_r;       // registered multiplier output
  logic signed [47:0] acc_r;        // coefficient sum, scale 2^-41
  logic signed [30:0] m_r;          // coefficient, Q.30
  logic signed [31:0] y_r;          // section output
  logic [STG_W-1:0]   stage_r;

  logic [DEPTH-1:0]   vld_r;        // state entry written since reset

  logic               out_valid_r;
  logic signed [23:0] out_sample_r;
  logic               out_last_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [ADDR_W-1:0]  addr;
  logic [31:0]        ram_rdata;
  logic signed [31:0] s_val;
  logic signed [31:0] ns_val;
  logic               ram_we;
  logic               last_stage;
  logic               out_free;

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_sample_out     = out_sample_r;
  assign out_block_last_out = out_last_r;
  assign out_free           = !out_valid_r || out_ready;
  assign last_stage         = (stage_r == STG_W'(NUM_STAGES - 1));

  // Entry of (channel, section): channel-major
  assign addr = ADDR_W'(stage_r) + (ch_r ? ADDR_W'(NUM_STAGES) : ADDR_W'(0));

  // Shared multiplier operand select
  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    unique case (state_r)
      S_M1: begin
        mul_a = 32'(mod_r);
        mul_b = $signed({15'd0, depth_r});
      end
      S_M2: begin
        mul_a = $signed({14'd0, DEPTH_ONE - {1'b0, depth_r}});
        mul_b = C965;
      end
      S_P1: begin
        mul_a = 32'(m_r);
        mul_b = x_r;
      end
      S_P2: begin
        mul_a = 32'(m_r);
        mul_b = y_r;
      end
      default: begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Section state store
  assign ram_we = (state_r == S_WR);
  assign s_val  = vld_r[addr] ? $signed(ram_rdata) : 32'sd0;
  assign ns_val = sat32(64'(x_r) - rnd30(prod_r));

  mac_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ns_val),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = S_P1;
      S_P1:    state_nxt = S_Y;     // read for this entry issued here; data is used in S_Y
      S_Y:     state_nxt = S_P2;
      S_P2:    state_nxt = S_WR;
      S_WR:    state_nxt = last_stage ? S_DONE : S_P1;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      stage_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        vld_r[addr] <= 1'b1;
      end
      if (state_r == S_IDLE) begin
        stage_r <= '0;
      end else if (state_r == S_WR) begin
        stage_r <= last_stage ? '0 : stage_r + 1'b1;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_r     <= 32'(in_sample_in);
          ch_r    <= (NUM_CHANNELS > 1) ? in_chan : 1'b0;
          mod_r   <= in_mod_in;
          depth_r <= in_depth_in;
          last_r  <= in_block_last;
        end
      end
      S_M2:   acc_r <= prod_r[47:0] <<< 9;       // mod*depth*512
      S_M3:   acc_r <= acc_r - prod_r[47:0];     // minus (1-depth/2)*0.965 term
      S_M4:   m_r   <= coef_q30(acc_r);
      S_Y:    y_r   <= sat32(64'(s_val) + rnd30(prod_r));
      S_WR:   x_r   <= y_r;
      S_DONE: begin
        if (out_free) begin
          out_sample_r <= sat24(x_r);
          out_last_r   <= last_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_M1))
    else $error("accepted request did not start coefficient build");

  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r <= STG_W'(NUM_STAGES - 1)))
    else $error("section counter out of range");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result loaded outside the final state");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("ready raised while a request is in flight");

endmodule
